// ===== sv/fpr_pkg.sv =====
// fpr_pkg: shared types and codes for the queue with positional remove.
// No dependencies; used by fpr_ctrl, fpr_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // item kinds
  localparam logic KIND_PUSH   = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic       push_en;    // append value at tail
    logic       remove_en;  // take out entry at position, close gap
    logic       load;       // capture result registers
    logic [1:0] status;     // status of the current item
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;     // occupancy == DEPTH
    logic empty;    // occupancy == 0
    logic pos_bad;  // position past tail or past DEPTH
  } flags_t;

endpackage

`default_nettype wire

// ===== sv/fpr_ctrl.sv =====
// fpr_ctrl: controller; decodes an item against queue flags and drives the result strobe.
// Depends on fpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            kind,
  input  fpr_pkg::flags_t      flags,
  output fpr_pkg::cmd_t        cmd,
  output logic                 done
);
  import fpr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    cmd = '0;
    cmd.load = start;
    if (kind == KIND_PUSH) begin
      if (flags.full) begin
        cmd.status = ST_FULL;
      end else begin
        cmd.status  = ST_OK;
        cmd.push_en = start;
      end
    end else begin
      if (flags.empty) begin
        cmd.status = ST_EMPTY;
      end else if (flags.pos_bad) begin
        cmd.status = ST_RANGE;
      end else begin
        cmd.status    = ST_OK;
        cmd.remove_en = start;
      end
    end
  end

  // one response cycle follows every accepted item
  always_comb begin
    unique case (state)
      S_IDLE:  state_next = start ? S_RESP : S_IDLE;
      S_RESP:  state_next = start ? S_RESP : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign done = (state == S_RESP);

endmodule

`default_nettype wire

// ===== sv/fpr_dp.sv =====
// fpr_dp: datapath; entry registers with parallel gap-closing shift, occupancy, result registers.
// Depends on fpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpr_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [31:0] value,
  input  wire logic        [3:0]  position,
  input  fpr_pkg::cmd_t           cmd,
  output fpr_pkg::flags_t         flags,
  output logic signed      [31:0] removed_value,
  output logic             [1:0]  status,
  output logic             [4:0]  entry_count
);
  import fpr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + 4;

  function automatic logic [PW-1:0] count_next_ext(input logic [CW-1:0] c);
    count_next_ext = {4'b0, c};
  endfunction

  logic signed [31:0] entries [DEPTH];
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [PW-1:0]      pos_ext;
  logic [PW-1:0]      count_ext;
  logic [PW+4:0]      count_wide;
  logic signed [31:0] rd_data;

  assign pos_ext   = {{CW{1'b0}}, position};
  assign count_ext = {4'b0, count};

  assign flags.full    = (count == CW'(DEPTH));
  assign flags.empty   = (count == '0);
  assign flags.pos_bad = (pos_ext >= count_ext) || (pos_ext >= PW'(DEPTH));

  // position is in range whenever it is read for a successful remove
  assign rd_data = entries[pos_ext[AW-1:0]];

  always_comb begin
    count_next = count;
    if (cmd.push_en) begin
      count_next = count + 1'b1;
    end else if (cmd.remove_en) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.push_en && (count == CW'(i))) begin
        entries[i] <= value;
      end else if (cmd.remove_en && (PW'(i) >= pos_ext) && (i < DEPTH - 1)) begin
        entries[i] <= entries[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign count_wide = {5'b0, count_next_ext(count_next)};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      removed_value <= cmd.remove_en ? rd_data : 32'sd0;
      status        <= cmd.status;
      entry_count   <= count_wide[4:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/fifo_with_positional_remove_top.sv =====
// fifo_with_positional_remove_top: ordered queue of signed 32-bit values with
// remove-at-position. Depends on fpr_pkg, fpr_ctrl and fpr_dp.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  item in | start & !busy      | kind, value, position
//  result  | done (1-cycle)     | removed_value, status, entry_count
//
// One item per clock: an item accepted at an edge updates the entry registers
// and occupancy at that same edge, and its result is shown with done for
// exactly the following cycle. The gap-closing shift acts on all entries at
// once, so busy stays low. Synchronous reset empties the queue; entry
// contents are not cleared. The receiver cannot stall; results are not held.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_positional_remove_top #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               kind,
  input  wire logic signed [31:0] value,
  input  wire logic        [3:0]  position,
  output logic                    done,
  output logic signed      [31:0] removed_value,
  output logic             [1:0]  status,
  output logic             [4:0]  entry_count
);
  import fpr_pkg::*;

  cmd_t   cmd;
  flags_t flags;
  logic   start_acc;

  // the queue takes an item every cycle
  assign busy      = 1'b0;
  assign start_acc = start & ~busy;

  // decode: status from kind and queue flags, enables for the datapath
  fpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start_acc),
    .kind  (kind),
    .flags (flags),
    .cmd   (cmd),
    .done  (done)
  );

  // storage, occupancy and result registers
  fpr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .value         (value),
    .position      (position),
    .cmd           (cmd),
    .flags         (flags),
    .removed_value (removed_value),
    .status        (status),
    .entry_count   (entry_count)
  );

`ifndef SYNTHESIS
  // every accepted item gets its result in the next cycle
  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    start_acc |=> done)
    else $error("result strobe missing after accepted item");

  // no result without an item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !start_acc |=> !done)
    else $error("result strobe without an accepted item");

  // a refused item or a push returns zero
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    done && ((status != ST_OK) || !$past(kind)) |-> removed_value == 32'sd0)
    else $error("nonzero value on push or refused remove");

  // a full status only ever follows a push
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> $past(kind) == KIND_PUSH)
    else $error("full status on a remove");
`endif

endmodule

`default_nettype wire
